>>> design/q4_block_matvec_engine_unit_defines.svh
// Assertion macros for the checker of the q4 block matvec engine
`ifndef Q4_BLOCK_MATVEC_ENGINE_UNIT_DEFINES_SVH
`define Q4_BLOCK_MATVEC_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define Q4BM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define Q4BM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/q4bm_pkg.sv
// Types, constants and helper functions of the q4 block matvec engine
`timescale 1ns / 1ps
`default_nettype none
package q4bm_pkg;

	localparam int MAX_VECTOR_LEN = 8192;
	localparam int BLOCK_WEIGHTS  = 32;
	localparam int MAX_BLOCKS     = 256;

	localparam int IN_DATA_W  = 224;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int GROUP_W    = 10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_ROW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_PASS  = 1'd1;

	// input kinds
	localparam logic CMD_LOAD_ACT = 1'b0;
	localparam logic CMD_WEIGHTS  = 1'b1;

	localparam logic [4:0] EXP_SPECIAL = 5'h1F;

	typedef struct packed {
		logic                 cmd;
		logic [GROUP_W-1:0]   act_group;
		logic [63:0]          act_bytes;
		logic [15:0]          scale_half;
		logic [63:0]          quant_lo;
		logic [63:0]          quant_hi;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t item;
	} q_head_t;

	typedef struct packed {
		logic signed [63:0] row_sum;
		logic [15:0]        row_number;
		logic               last_row;
		logic               saturated;
		logic               nonfinite_scale;
	} result_t;

	// Dot product of eight activations with eight nibbles (four weight bytes)
	function automatic logic signed [15:0] nib_dot8(input logic [63:0] acts,
			input logic [31:0] qb);
		logic signed [15:0] w;
		logic signed [15:0] a;
		logic signed [15:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			w = $signed({12'd0, qb[4*i +: 4]}) - 16'sd8;
			a = 16'($signed(acts[8*i +: 8]));
			s = s + w * a;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

>>> design/q4_block_matvec_engine_unit.sv
// Top level of the q4 block matvec engine: config registers, front end, back end
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: group, acts, scale, qlo, qhi; tuser: cmd
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: sum, row; tlast; tuser: flags
// cfg       in   cfg_we                         cfg_index, cfg_wdata
//
// An activation load is written into the activation store from the queue head; a
// weight block steps through four reads of the activation store, then the multiply,
// shift-accumulate and row-end steps. A two-entry queue decouples the input side.
// Reset clears counters, accumulator and flags; the activation store is not
// cleared. A stalled output holds the back end at the row end only.
`timescale 1ns / 1ps
`default_nettype none
module q4_block_matvec_engine_unit #(
	parameter int MAX_VECTOR_LEN = q4bm_pkg::MAX_VECTOR_LEN
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// act_group[9:0], act_bytes[73:10], scale_half[89:74], quant_lo[153:90],
	// quant_hi[217:154], zero fill
	input  wire logic [q4bm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  wire logic                            s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// row_sum[63:0], row_number[79:64]
	output logic [q4bm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// saturated[0], nonfinite_scale[1]
	output logic [q4bm_pkg::OUT_USER_W-1:0]      m_axis_tuser,
	output logic                                 m_axis_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [q4bm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [q4bm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [8:0]        bpr_q;
	logic [15:0]       rpp_q;
	q4bm_pkg::q_head_t head;
	logic              pop;
	q4bm_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpr_q <= 9'd1;
			rpp_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				q4bm_pkg::REG_BLOCKS_PER_ROW: bpr_q <= cfg_wdata[8:0];
				q4bm_pkg::REG_ROWS_PER_PASS:  rpp_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	q4bm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.pop           (pop),
		.head          (head)
	);

	q4bm_back #(
		.MAX_VECTOR_LEN (MAX_VECTOR_LEN)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.blocks_per_row (bpr_q),
		.rows_per_pass  (rpp_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_res        (res)
	);

	assign m_axis_tdata = {res.row_number, res.row_sum};
	assign m_axis_tuser = {res.nonfinite_scale, res.saturated};
	assign m_axis_tlast = res.last_row;

endmodule
`default_nettype wire

>>> design/q4bm_front.sv
// Front end: accepts stream items, unpacks them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module q4bm_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [q4bm_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic                           s_axis_tuser,
	input  wire logic                           pop,
	output q4bm_pkg::q_head_t                   head
);

	q4bm_pkg::entry_t fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	q4bm_pkg::entry_t in_item;
	logic             push;
	logic             do_pop;

	always_comb begin
		in_item.cmd        = s_axis_tuser;
		in_item.act_group  = s_axis_tdata[9:0];
		in_item.act_bytes  = s_axis_tdata[73:10];
		in_item.scale_half = s_axis_tdata[89:74];
		in_item.quant_lo   = s_axis_tdata[153:90];
		in_item.quant_hi   = s_axis_tdata[217:154];
	end

	assign s_axis_tready = (count_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign do_pop        = pop && (count_q != 2'd0);
	assign head          = {(count_q != 2'd0), fifo_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

>>> design/q4bm_back.sv
// Back end: activation store, block dot product, scaling and row accumulation
`timescale 1ns / 1ps
`default_nettype none
module q4bm_back #(
	parameter int MAX_VECTOR_LEN = q4bm_pkg::MAX_VECTOR_LEN
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire q4bm_pkg::q_head_t head,
	output logic                   pop,
	input  wire logic [8:0]        blocks_per_row,
	input  wire logic [15:0]       rows_per_pass,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output q4bm_pkg::result_t      out_res
);

	localparam int DEPTH = MAX_VECTOR_LEN / 8;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = q4bm_pkg::GROUP_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SHF  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [63:0]        mem [DEPTH];
	logic [2:0]         st_q;
	logic [2:0]         k_q;
	logic               rd_v_s1;
	logic [1:0]         rd_k_s1;
	logic [63:0]        rd_data_s1;
	q4bm_pkg::entry_t   cur_q;
	logic signed [16:0] dot_q;
	logic [26:0]        prod_q;
	logic               neg_q;
	logic [4:0]         shift_q;
	logic signed [63:0] acc_q;
	logic               clip_q;
	logic               spec_q;
	logic [7:0]         blk_q;
	logic [15:0]        row_q;
	logic               out_v_q;
	q4bm_pkg::result_t  out_q;

	logic [IW-1:0]      widx;
	logic [IW-1:0]      ridx;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic               we;
	logic               re;
	logic [4:0]         ex;
	logic [10:0]        mant;
	logic [16:0]        absdot;
	logic [63:0]        mag;
	logic signed [63:0] term;
	logic signed [64:0] sum;
	logic [8:0]         bpr_eff;
	logic [15:0]        rpp_eff;
	logic               row_end;
	logic               last;
	logic               emit;
	logic [127:0]       qbits;
	logic signed [15:0] part;

	assign widx = head.item.act_group;
	assign ridx = {blk_q, k_q[1:0]};

	generate
		if (AW <= IW) begin : g_narrow
			assign waddr = widx[AW-1:0];
			assign raddr = ridx[AW-1:0];
		end else begin : g_wide
			assign waddr = {{(AW-IW){1'b0}}, widx};
			assign raddr = {{(AW-IW){1'b0}}, ridx};
		end
	endgenerate

	assign pop = (st_q == ST_IDLE) && head.valid;
	assign we  = pop && (head.item.cmd == q4bm_pkg::CMD_LOAD_ACT);
	assign re  = (st_q == ST_RD) && !k_q[2];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= head.item.act_bytes;
		end
		rd_data_s1 <= mem[raddr];
		rd_k_s1    <= k_q[1:0];
	end

	always_comb begin
		ex      = cur_q.scale_half[14:10];
		mant    = {(ex != 5'd0), cur_q.scale_half[9:0]};
		absdot  = dot_q[16] ? 17'(-dot_q) : 17'(dot_q);
		mag     = {37'd0, prod_q} << shift_q;
		term    = neg_q ? -$signed(mag) : $signed(mag);
		sum     = {acc_q[63], acc_q} + {term[63], term};
		qbits   = {cur_q.quant_hi, cur_q.quant_lo};
		part    = q4bm_pkg::nib_dot8(rd_data_s1, qbits[32*rd_k_s1 +: 32]);
		bpr_eff = (blocks_per_row == 9'd0) ? 9'd1 :
			(blocks_per_row > 9'(q4bm_pkg::MAX_BLOCKS)) ? 9'(q4bm_pkg::MAX_BLOCKS) :
			blocks_per_row;
		rpp_eff = (rows_per_pass == 16'd0) ? 16'd1 : rows_per_pass;
		row_end = ({1'b0, blk_q} + 9'd1) >= bpr_eff;
		last    = ({1'b0, row_q} + 17'd1) >= {1'b0, rpp_eff};
		emit    = (st_q == ST_FIN) && row_end && (!out_v_q || out_ready);
	end

	always_ff @(posedge clk) begin
		if (pop && head.item.cmd == q4bm_pkg::CMD_WEIGHTS) begin
			cur_q <= head.item;
		end
		if (st_q == ST_MUL) begin
			prod_q  <= 27'(mant) * 27'(absdot[15:0]);
			neg_q   <= cur_q.scale_half[15] ^ dot_q[16];
			shift_q <= (ex == 5'd0) ? 5'd0 : ex - 5'd1;
		end
		if (emit) begin
			out_q.row_sum         <= acc_q;
			out_q.row_number      <= row_q;
			out_q.last_row        <= last;
			out_q.saturated       <= clip_q;
			out_q.nonfinite_scale <= spec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			k_q     <= 3'd0;
			rd_v_s1 <= 1'b0;
			dot_q   <= '0;
			acc_q   <= '0;
			clip_q  <= 1'b0;
			spec_q  <= 1'b0;
			blk_q   <= 8'd0;
			row_q   <= 16'd0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= re;
			if (rd_v_s1) begin
				dot_q <= dot_q + 17'(part);
			end
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop && head.item.cmd == q4bm_pkg::CMD_WEIGHTS) begin
						k_q   <= 3'd0;
						dot_q <= '0;
						st_q  <= ST_RD;
					end
				end
				ST_RD: begin
					k_q <= k_q + 3'd1;
					if (k_q[2]) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (ex == q4bm_pkg::EXP_SPECIAL) begin
						spec_q <= 1'b1;
						st_q   <= ST_FIN;
					end else begin
						st_q <= ST_SHF;
					end
				end
				ST_SHF: begin
					// clip when the sign bits of the widened sum disagree
					if (sum[64] != sum[63]) begin
						clip_q <= 1'b1;
						acc_q  <= sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					end else begin
						acc_q <= sum[63:0];
					end
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!row_end) begin
						blk_q <= blk_q + 8'd1;
						st_q  <= ST_IDLE;
					end else if (emit) begin
						out_v_q <= 1'b1;
						row_q   <= last ? 16'd0 : row_q + 16'd1;
						blk_q   <= 8'd0;
						acc_q   <= '0;
						clip_q  <= 1'b0;
						spec_q  <= 1'b0;
						st_q    <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule
`default_nettype wire

>>> design/q4bm_checker.sv
// Port-level checker for the q4 block matvec engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "q4_block_matvec_engine_unit_defines.svh"
module q4bm_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [q4bm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [q4bm_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input wire logic                            m_axis_tlast
);

	logic [15:0] exp_row_q;

	// track the row number the next result must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_row_q <= 16'd0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			exp_row_q <= m_axis_tlast ? 16'd0 : m_axis_tdata[79:64] + 16'd1;
		end
	end

	`Q4BM_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid, "result dropped while stalled")
	`Q4BM_ASSERT_NEXT(a_hold_data, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
		"result changed while stalled")
	`Q4BM_ASSERT_NOW(a_row_seq, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[79:64] == exp_row_q, "row number out of sequence")

endmodule

bind q4_block_matvec_engine_unit q4bm_checker u_q4bm_checker (.*);
`default_nettype wire
